// ===== src/mtfq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mtfq_pkg;

  // Sizing of the entry store
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = CNT_W + 1;

  // Port field widths
  localparam int KIND_W   = 3;
  localparam int ID_W     = 16;
  localparam int AGE_W    = 8;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 5;

  localparam int ENTRY_W = ID_BITS + AGE_W;

  // Operation codes
  localparam logic [KIND_W-1:0] OP_APPEND  = 3'd0;
  localparam logic [KIND_W-1:0] OP_POP     = 3'd1;
  localparam logic [KIND_W-1:0] OP_PROMOTE = 3'd2;
  localparam logic [KIND_W-1:0] OP_FIND    = 3'd3;
  localparam logic [KIND_W-1:0] OP_MODIFY  = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNCHANGED = 3'd4;

  typedef logic [ID_W-1:0]     id_t;
  typedef logic [AGE_W-1:0]    age_t;
  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [OCC_W-1:0]    occ_t;

  // Physical slot of a logical position in the ring
  function automatic logic [PTR_W-1:0] ring_addr(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] offs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(offs);
    if (sum >= SUM_W'(QUEUE_DEPTH)) begin
      sum = sum - SUM_W'(QUEUE_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/mtfq_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Operation request channel
interface mtfq_in_if
  import mtfq_pkg::*;
;
  logic  valid;
  logic  ready;
  kind_t kind;
  id_t   entry_id;
  age_t  entry_age;

  modport source (output valid, output kind, output entry_id, output entry_age,
                  input ready);
  modport sink   (input valid, input kind, input entry_id, input entry_age,
                  output ready);
endinterface

// Operation result channel
interface mtfq_out_if
  import mtfq_pkg::*;
;
  logic    valid;
  logic    ready;
  status_t status;
  id_t     out_id;
  age_t    out_age;
  occ_t    occupancy;

  modport source (output valid, output status, output out_id, output out_age,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_id, input out_age,
                  input occupancy, output ready);
endinterface

`default_nettype wire

// ===== src/queue_with_move_to_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel    Dir  Fields                                  Handshake
// in_chan    in   kind, entry_id, entry_age               valid/ready
// out_chan   out  status, out_id, out_age, occupancy      valid/ready
//
// Entries live in a ring buffer (one write port, one registered read port).
// Append and rejected ops go straight to the result state, pop reads the head
// first, find and modify scan entry by entry, and promote also shifts the entries
// ahead of the match back and writes the match at the head. A new op is taken only in idle.
// Synchronous active-low reset empties the queue; no clearing pass is needed.
// A finished result waits in its state until the output register is free.

module queue_with_move_to_front
  import mtfq_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  mtfq_in_if.sink    in_chan,
  mtfq_out_if.source out_chan
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_POP      = 3'd1;
  localparam logic [2:0] S_SCAN_RD  = 3'd2;
  localparam logic [2:0] S_SCAN_CMP = 3'd3;
  localparam logic [2:0] S_SHIFT_RD = 3'd4;
  localparam logic [2:0] S_SHIFT_WR = 3'd5;
  localparam logic [2:0] S_FRONT_WR = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]               state_r, state_nxt;
  logic [PTR_W-1:0]         head_r, head_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  kind_t                    op_r, op_nxt;
  logic [ID_BITS-1:0]       id_r, id_nxt;
  age_t                     age_r, age_nxt;
  logic [ENTRY_W-1:0]       hold_r, hold_nxt;
  status_t                  res_status_r, res_status_nxt;
  id_t                      res_id_r, res_id_nxt;
  age_t                     res_age_r, res_age_nxt;
  logic                     out_valid_r, out_valid_nxt;
  status_t                  out_status_r, out_status_nxt;
  id_t                      out_id_r, out_id_nxt;
  age_t                     out_age_r, out_age_nxt;
  occ_t                     out_occ_r, out_occ_nxt;

  // Entry store
  logic [ENTRY_W-1:0]       mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0]       rd_data_r;
  logic [PTR_W-1:0]         rd_addr;
  logic                     wr_en;
  logic [PTR_W-1:0]         wr_addr;
  logic [ENTRY_W-1:0]       wr_data;

  logic [ID_BITS-1:0]       rd_id;
  age_t                     rd_age;
  logic                     accept;
  logic                     out_free;

  assign rd_id  = rd_data_r[ENTRY_W-1:AGE_W];
  assign rd_age = rd_data_r[AGE_W-1:0];

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && (state_r == S_IDLE);
  assign out_free      = !out_valid_r || out_chan.ready;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = out_status_r;
  assign out_chan.out_id    = out_id_r;
  assign out_chan.out_age   = out_age_r;
  assign out_chan.occupancy = out_occ_r;

  // Write and read the store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Sequence one transaction
  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    age_nxt        = age_r;
    hold_nxt       = hold_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_age_nxt    = res_age_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_age_nxt    = out_age_r;
    out_occ_nxt    = out_occ_r;
    rd_addr        = head_r;
    wr_en          = 1'b0;
    wr_addr        = head_r;
    wr_data        = {id_r, age_r};

    // Drop the output once taken
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt         = in_chan.kind;
          id_nxt         = in_chan.entry_id[ID_BITS-1:0];
          age_nxt        = in_chan.entry_age;
          res_status_nxt = ST_OK;
          res_id_nxt     = '0;
          res_age_nxt    = '0;
          idx_nxt        = '0;
          state_nxt      = S_DONE;
          case (in_chan.kind)
            OP_APPEND: begin
              if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = ring_addr(head_r, count_r);
                wr_data   = {in_chan.entry_id[ID_BITS-1:0], in_chan.entry_age};
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_POP;
              end
            end
            OP_PROMOTE: begin
              if (count_r < CNT_W'(2)) begin
                res_status_nxt = ST_UNCHANGED;
              end else begin
                idx_nxt   = CNT_W'(1);
                state_nxt = S_SCAN_RD;
              end
            end
            OP_FIND, OP_MODIFY: begin
              if (count_r == '0) begin
                res_status_nxt = ST_NOT_FOUND;
              end else begin
                state_nxt = S_SCAN_RD;
              end
            end
            default: begin
              res_status_nxt = ST_UNCHANGED;
            end
          endcase
        end
      end

      // Head entry arrives from the read issued at accept
      S_POP: begin
        res_id_nxt  = id_t'(rd_id);
        res_age_nxt = rd_age;
        head_nxt    = ring_addr(head_r, CNT_W'(1));
        count_nxt   = count_r - CNT_W'(1);
        state_nxt   = S_DONE;
      end

      S_SCAN_RD: begin
        rd_addr   = ring_addr(head_r, idx_r);
        state_nxt = S_SCAN_CMP;
      end

      // Compare one entry, advance or finish
      S_SCAN_CMP: begin
        if (rd_id == id_r) begin
          case (op_r)
            OP_MODIFY: begin
              wr_en       = 1'b1;
              wr_addr     = ring_addr(head_r, idx_r);
              wr_data     = {rd_id, age_r};
              res_id_nxt  = id_t'(rd_id);
              res_age_nxt = age_r;
              state_nxt   = S_DONE;
            end
            OP_PROMOTE: begin
              hold_nxt  = rd_data_r;
              state_nxt = S_SHIFT_RD;
            end
            default: begin
              res_id_nxt  = id_t'(rd_id);
              res_age_nxt = rd_age;
              state_nxt   = S_DONE;
            end
          endcase
        end else if (idx_r + CNT_W'(1) >= count_r) begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_SCAN_RD;
        end
      end

      // Move the entries ahead of the match back by one
      S_SHIFT_RD: begin
        rd_addr   = ring_addr(head_r, idx_r - CNT_W'(1));
        state_nxt = S_SHIFT_WR;
      end

      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = ring_addr(head_r, idx_r);
        wr_data = rd_data_r;
        idx_nxt = idx_r - CNT_W'(1);
        if (idx_r == CNT_W'(1)) begin
          state_nxt = S_FRONT_WR;
        end else begin
          state_nxt = S_SHIFT_RD;
        end
      end

      // Place the matched entry at the head
      S_FRONT_WR: begin
        wr_en     = 1'b1;
        wr_addr   = head_r;
        wr_data   = hold_r;
        state_nxt = S_DONE;
      end

      // Hand the result to the output register
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_id_nxt     = res_id_r;
          out_age_nxt    = res_age_r;
          out_occ_nxt    = occ_t'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    age_r        <= age_nxt;
    hold_r       <= hold_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_age_r    <= res_age_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_age_r    <= out_age_nxt;
    out_occ_r    <= out_occ_nxt;
  end

endmodule

`default_nettype wire
